/* hdl/cslc_pkg.sv */
// shared types, constants and helpers for the scrollback console
// no dependencies
package cslc_pkg;

  localparam int HISTORY_DEPTH  = 64;
  localparam int SCREEN_ROWS    = 4;
  localparam int SCREEN_COLS    = 20;
  localparam int LINE_W         = $clog2(HISTORY_DEPTH);
  localparam int ROW_W          = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
  localparam int COL_W          = $clog2(SCREEN_COLS + 1);
  localparam int WORDS_PER_LINE = (SCREEN_COLS + 3) / 4;
  localparam int WRD_W          = $clog2(WORDS_PER_LINE);
  localparam int MEM_WORDS      = HISTORY_DEPTH * WORDS_PER_LINE;
  localparam int MEM_AW         = $clog2(MEM_WORDS);
  localparam int VIEW_MAX       = HISTORY_DEPTH - SCREEN_ROWS;
  localparam int RES_DEPTH      = 4;
  localparam int RES_AW         = $clog2(RES_DEPTH);

  // input command codes
  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_UP   = 2'd1;
  localparam logic [1:0] CMD_DOWN = 2'd2;

  // character codes
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;

  // result kinds
  localparam logic KIND_CURSOR = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  typedef enum logic [2:0] {
    OP_SCROLL_UP,
    OP_SCROLL_DN,
    OP_PRINT,
    OP_BACKSPACE,
    OP_NEWLINE
  } op_e;

  typedef struct packed {
    op_e        code;
    logic [7:0] ch;
  } op_t;

  typedef struct packed {
    logic        kind;
    logic [6:0]  addr;
    logic [2:0]  cnt;
    logic [31:0] chars;
    logic        last;
  } res_t;

  // display ram address of a row and column
  function automatic logic [6:0] disp_addr(input logic [ROW_W-1:0] row,
                                           input logic [5:0] col,
                                           input logic [5:0] off);
    logic [7:0] a;
    a = {1'b0, row[0], 6'b0} + {2'b0, col};
    if (row >= ROW_W'(2)) begin
      a = a + {2'b0, off};
    end
    return a[6:0];
  endfunction

endpackage

/* hdl/cslc_front.sv */
// front end: input handshake, escape filtering and command classification
// depends on cslc_pkg
module cslc_front import cslc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] cmd_i,
  input  logic [7:0] ch_i,
  input  logic       q_full_i,
  input  logic       busy_i,
  output logic       op_push_o,
  output op_t        op_o
);

  typedef enum logic [1:0] {
    ESC_NORMAL,
    ESC_SEEN,
    ESC_CSI
  } esc_e;

  esc_e esc_q, esc_d;
  logic accept;
  logic is_letter;

  assign full   = q_full_i | busy_i;
  assign accept = push & ~full;
  assign is_letter = ((ch_i >= 8'h41) && (ch_i <= 8'h5a)) ||
                     ((ch_i >= 8'h61) && (ch_i <= 8'h7a));

  // classify one request
  always_comb begin
    esc_d     = esc_q;
    op_push_o = 1'b0;
    op_o.code = OP_PRINT;
    op_o.ch   = ch_i;
    if (accept) begin
      unique case (cmd_i)
        CMD_UP: begin
          op_push_o = 1'b1;
          op_o.code = OP_SCROLL_UP;
        end
        CMD_DOWN: begin
          op_push_o = 1'b1;
          op_o.code = OP_SCROLL_DN;
        end
        CMD_CHAR: begin
          if (esc_q == ESC_CSI) begin
            if (is_letter) esc_d = ESC_NORMAL;
          end else if (esc_q == ESC_SEEN && ch_i == CH_LBRK) begin
            esc_d = ESC_CSI;
          end else begin
            esc_d = ESC_NORMAL;
            if (ch_i == CH_ESC) begin
              esc_d = ESC_SEEN;
            end else if (ch_i == CH_BS || ch_i == CH_DEL) begin
              op_push_o = 1'b1;
              op_o.code = OP_BACKSPACE;
            end else if (ch_i == CH_LF || ch_i == CH_CR) begin
              op_push_o = 1'b1;
              op_o.code = OP_NEWLINE;
            end else if (ch_i >= CH_SPACE && ch_i <= CH_TILDE) begin
              op_push_o = 1'b1;
              op_o.code = OP_PRINT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // escape phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= ESC_NORMAL;
    end else begin
      esc_q <= esc_d;
    end
  end

endmodule

/* hdl/cslc_op_queue.sv */
// two-entry queue of classified commands between front and back end
// depends on cslc_pkg
module cslc_op_queue import cslc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  op_o
);

  op_t        mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o    = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= op_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* hdl/cslc_res_queue.sv */
// result queue feeding the output side
// depends on cslc_pkg
module cslc_res_queue import cslc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  res_t            res_i,
  output logic [RES_AW:0] free_o,
  input  logic            pop,
  output logic            empty,
  output res_t            res_o
);

  res_t              mem_q [RES_DEPTH];
  logic [RES_AW-1:0] wr_q, rd_q;
  logic [RES_AW:0]   cnt_q;
  logic              do_push, do_pop;

  assign free_o  = (RES_AW+1)'(RES_DEPTH) - cnt_q;
  assign empty   = (cnt_q == '0);
  assign res_o   = mem_q[rd_q];
  assign do_push = push_i & (free_o != '0);
  assign do_pop  = pop & ~empty;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= res_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (RES_AW+1)'(do_push) - (RES_AW+1)'(do_pop);
    end
  end

endmodule

/* hdl/cslc_back.sv */
// back end: history memory, cursor and view state, redraw sequencer
// depends on cslc_pkg
module cslc_back import cslc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            op_valid_i,
  input  op_t             op_i,
  output logic            op_pop_o,
  input  logic [5:0]      row_off_i,
  input  logic [4:0]      prot_cols_i,
  input  logic [RES_AW:0] res_free_i,
  output logic            res_push_o,
  output res_t            res_o,
  output logic            busy_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADV,
    S_REDRAW,
    S_DRAIN,
    S_CURSOR,
    S_PRINT,
    S_BS_WR,
    S_BS_CUR
  } state_e;

  state_e            state_q;
  logic [MEM_AW-1:0] clr_q;
  logic [LINE_W-1:0] head_q, view_q, view_nx;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [WRD_W-1:0]  wrd_q;
  logic [7:0]        ch_q;
  logic              tail_q, cur_after_q;
  logic              rd_pend_q, rd_last_q;
  logic [6:0]        rd_addr_q;
  logic [2:0]        rd_cnt_q;

  logic [3:0][7:0]   hist_mem [MEM_WORDS];
  logic [31:0]       rdata_q;
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [3:0]        mem_wbe;
  logic [31:0]       mem_wdata;

  logic [LINE_W-1:0] rd_line;
  logic [MEM_AW-1:0] head_base;
  logic [5:0]        wcol, wrem;
  logic [2:0]        wcnt;
  logic [6:0]        cur_addr, red_addr;
  logic              red_end, room, step;
  logic [31:0]       rd_chars;

  // address arithmetic
  assign rd_line   = head_q - LINE_W'(SCREEN_ROWS - 1) - view_q + LINE_W'(row_q);
  assign head_base = MEM_AW'(head_q) * MEM_AW'(WORDS_PER_LINE);
  assign wcol      = 6'(wrd_q) << 2;
  assign wrem      = 6'(SCREEN_COLS) - wcol;
  assign wcnt      = (wrem >= 6'd4) ? 3'd4 : wrem[2:0];
  assign cur_addr  = disp_addr(ROW_W'(SCREEN_ROWS - 1), 6'(col_q), row_off_i);
  assign red_addr  = disp_addr(row_q, wcol, row_off_i);
  assign red_end   = (row_q == ROW_W'(SCREEN_ROWS - 1)) &&
                     (wrd_q == WRD_W'(WORDS_PER_LINE - 1));
  assign room      = (res_free_i != '0);
  assign busy_o    = (state_q == S_CLEAR);

  // mask of unused bytes in a fetched word
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_chars[8*k +: 8] = (3'(k) < rd_cnt_q) ? rdata_q[8*k +: 8] : 8'h00;
    end
  end

  // memory port, result push and step control
  always_comb begin
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = head_base + MEM_AW'(col_q[COL_W-1:2]);
    mem_raddr  = MEM_AW'(rd_line) * MEM_AW'(WORDS_PER_LINE) + MEM_AW'(wrd_q);
    mem_wbe    = 4'b0001 << col_q[1:0];
    mem_wdata  = {4{CH_SPACE}};
    op_pop_o   = 1'b0;
    res_push_o = 1'b0;
    step       = 1'b0;
    res_o      = '{kind: KIND_CURSOR, addr: cur_addr, cnt: 3'd0, chars: 32'd0, last: 1'b1};
    if (rd_pend_q) begin
      res_push_o = 1'b1;
      res_o = '{kind: KIND_WRITE, addr: rd_addr_q, cnt: rd_cnt_q, chars: rd_chars,
                last: rd_last_q};
    end
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wbe   = 4'b1111;
      end
      S_IDLE: op_pop_o = op_valid_i;
      S_ADV: begin
        mem_we    = 1'b1;
        mem_waddr = head_base + MEM_AW'(wrd_q);
        mem_wbe   = 4'b1111;
      end
      S_REDRAW: begin
        step   = (res_free_i > (RES_AW+1)'(rd_pend_q));
        mem_re = step;
      end
      S_DRAIN: ;
      S_CURSOR: begin
        step       = room;
        res_push_o = room;
        res_o.last = ~tail_q;
      end
      S_PRINT: begin
        step       = room || (view_q != '0);
        mem_we     = step;
        mem_wdata  = {4{ch_q}};
        res_push_o = room && (view_q == '0);
        res_o      = '{kind: KIND_WRITE, addr: cur_addr, cnt: 3'd1,
                       chars: {24'd0, ch_q}, last: 1'b1};
      end
      S_BS_WR: begin
        step       = room || (view_q != '0);
        mem_we     = step;
        res_push_o = room && (view_q == '0);
        res_o      = '{kind: KIND_WRITE, addr: cur_addr, cnt: 3'd1,
                       chars: {24'd0, CH_SPACE}, last: 1'b0};
      end
      S_BS_CUR: begin
        step       = room;
        res_push_o = room;
      end
      default: ;
    endcase
  end

  // history memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int k = 0; k < 4; k++) begin
        if (mem_wbe[k]) hist_mem[mem_waddr][k] <= mem_wdata[8*k +: 8];
      end
    end
    if (mem_re) rdata_q <= hist_mem[mem_raddr];
  end

  // next view for scroll commands
  always_comb begin
    view_nx = view_q;
    if (op_i.code == OP_SCROLL_UP) begin
      if (view_q < LINE_W'(VIEW_MAX)) view_nx = view_q + 1'b1;
    end else if (view_q != '0) begin
      view_nx = view_q - 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      head_q      <= LINE_W'(SCREEN_ROWS - 1);
      view_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      wrd_q       <= '0;
      ch_q        <= '0;
      tail_q      <= 1'b0;
      cur_after_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      rd_addr_q   <= '0;
      rd_cnt_q    <= '0;
    end else begin
      rd_pend_q <= mem_re;
      if (mem_re) begin
        rd_addr_q <= red_addr;
        rd_cnt_q  <= wcnt;
        rd_last_q <= red_end && !cur_after_q;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == MEM_AW'(MEM_WORDS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (op_valid_i) begin
            ch_q  <= op_i.ch;
            row_q <= '0;
            wrd_q <= '0;
            unique case (op_i.code)
              OP_SCROLL_UP, OP_SCROLL_DN: begin
                view_q      <= view_nx;
                cur_after_q <= (view_nx == '0);
                tail_q      <= 1'b0;
                state_q     <= S_REDRAW;
              end
              OP_NEWLINE: begin
                if (col_q != '0) begin
                  col_q   <= '0;
                  head_q  <= head_q + 1'b1;
                  tail_q  <= 1'b0;
                  state_q <= S_ADV;
                end
              end
              OP_PRINT: begin
                if (col_q >= COL_W'(SCREEN_COLS)) begin
                  col_q   <= '0;
                  head_q  <= head_q + 1'b1;
                  tail_q  <= 1'b1;
                  state_q <= S_ADV;
                end else begin
                  state_q <= S_PRINT;
                end
              end
              OP_BACKSPACE: begin
                if (col_q > COL_W'(prot_cols_i)) begin
                  col_q   <= col_q - 1'b1;
                  state_q <= S_BS_WR;
                end
              end
              default: ;
            endcase
          end
        end
        S_ADV: begin
          wrd_q <= wrd_q + 1'b1;
          if (wrd_q == WRD_W'(WORDS_PER_LINE - 1)) begin
            wrd_q <= '0;
            if (view_q == '0) begin
              cur_after_q <= 1'b1;
              state_q     <= S_REDRAW;
            end else if (tail_q) begin
              state_q <= S_PRINT;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_REDRAW: begin
          if (step) begin
            wrd_q <= wrd_q + 1'b1;
            if (wrd_q == WRD_W'(WORDS_PER_LINE - 1)) begin
              wrd_q <= '0;
              row_q <= row_q + 1'b1;
            end
            if (red_end) state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_pend_q) begin
            if (cur_after_q) state_q <= S_CURSOR;
            else if (tail_q) state_q <= S_PRINT;
            else state_q <= S_IDLE;
          end
        end
        S_CURSOR: begin
          if (step) state_q <= tail_q ? S_PRINT : S_IDLE;
        end
        S_PRINT: begin
          if (step) begin
            col_q   <= col_q + 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_BS_WR: begin
          if (step) state_q <= (view_q == '0) ? S_BS_CUR : S_IDLE;
        end
        S_BS_CUR: begin
          if (step) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/char_lcd_scrollback_console_core.sv */
// top level of the lcd scrollback console: config registers and queues
// depends on cslc_pkg, cslc_front, cslc_op_queue, cslc_back, cslc_res_queue
// a printable character passes the op queue and the idle and print states before its
// write result; a scroll makes 20 word reads of the history memory, one per cycle while
// the result queue has room, plus a cursor set if the view ends at the bottom; a line
// advance also clears the new line. throughput is set by the back end sequencer and its
// single memory read port. after reset a clearing pass over all 320 history words fills
// the history with spaces; full stays high during it.
module char_lcd_scrollback_console_core import cslc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  ch_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [6:0]  ddram_addr_o,
  output logic [2:0]  char_count_o,
  output logic [31:0] chars_o,
  output logic        last_o
);

  logic [5:0]      row_off_q;
  logic [4:0]      prot_cols_q;
  logic            op_push, op_full, op_valid, op_pop, busy;
  op_t             op_in, op_out;
  logic            res_push;
  res_t            res_in, res_head;
  logic [RES_AW:0] res_free;

  // configuration registers
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {27'd0, prot_cols_q} : {26'd0, row_off_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_off_q   <= 6'd20;
      prot_cols_q <= 5'd5;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) prot_cols_q <= pwdata[4:0];
      else row_off_q <= pwdata[5:0];
    end
  end

  cslc_front u_front (
    .clk_i, .rst_ni, .push, .full, .cmd_i, .ch_i,
    .q_full_i(op_full), .busy_i(busy), .op_push_o(op_push), .op_o(op_in)
  );

  cslc_op_queue u_opq (
    .clk_i, .rst_ni, .push_i(op_push), .op_i(op_in), .full_o(op_full),
    .pop_i(op_pop), .valid_o(op_valid), .op_o(op_out)
  );

  cslc_back u_back (
    .clk_i, .rst_ni, .op_valid_i(op_valid), .op_i(op_out), .op_pop_o(op_pop),
    .row_off_i(row_off_q), .prot_cols_i(prot_cols_q), .res_free_i(res_free),
    .res_push_o(res_push), .res_o(res_in), .busy_o(busy)
  );

  cslc_res_queue u_resq (
    .clk_i, .rst_ni, .push_i(res_push), .res_i(res_in), .free_o(res_free),
    .pop, .empty, .res_o(res_head)
  );

  // result fields
  assign kind_o       = res_head.kind;
  assign ddram_addr_o = res_head.addr;
  assign char_count_o = res_head.cnt;
  assign chars_o      = res_head.chars;
  assign last_o       = res_head.last;

  // back end never pushes into a full result queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (res_free != '0)) else $error("result queue overflow");

  // no request taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> full) else $error("request accepted during clear");

  // cursor sets carry no characters
  a_cursor_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (kind_o == KIND_CURSOR)) |-> (char_count_o == 3'd0 && chars_o == 32'd0))
    else $error("cursor set with characters");

endmodule
